FILE: rtl/core/shl_pkg.sv
// Types, reset constants and GF(2) matrix functions for the shear linear layer.
`timescale 1ns / 1ps
`default_nettype none

package shl_pkg;

   localparam int NUM_ROWS    = 8;
   localparam int NUM_BYTES   = 16;
   localparam int NUM_STAGES  = 4;
   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 8;

   typedef logic [7:0] byte_type;
   typedef logic [NUM_ROWS-1:0][7:0] matrix_type;

   // Row i of the base matrix sits at index i.
   localparam matrix_type MATRIX_RESET = {8'h82, 8'hDE, 8'hC0, 8'h01,
                                          8'h14, 8'hF5, 8'h73, 8'hC8};

   typedef struct packed {
      logic [31:0] in_word_0;
      logic [31:0] in_word_1;
      logic [31:0] in_word_2;
      logic [31:0] in_word_3;
   } req_data_type;

   typedef struct packed {
      logic [31:0] out_word_0;
      logic [31:0] out_word_1;
      logic [31:0] out_word_2;
      logic [31:0] out_word_3;
   } rsp_data_type;

   // Output bit 7-i is the parity of row i masked with x.
   function automatic byte_type mat_apply(input matrix_type rows, input byte_type x);
      byte_type y;
      y = '0;
      for (int i = 0; i < NUM_ROWS; i++) begin
         y[7-i] = ^(rows[i] & x);
      end
      return y;
   endfunction

   // Quarter turn clockwise: bit k of row r comes from bit 7-r of row k.
   function automatic matrix_type mat_rotate(input matrix_type src);
      matrix_type dst;
      dst = '0;
      for (int r = 0; r < NUM_ROWS; r++) begin
         for (int k = 0; k < NUM_ROWS; k++) begin
            dst[r][k] = src[k][7-r];
         end
      end
      return dst;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/core/shl_if.sv
// Valid/ready channel interfaces for request and response blocks.
`timescale 1ns / 1ps
`default_nettype none

interface shl_req_if;
   logic                  valid;
   logic                  ready;
   shl_pkg::req_data_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface shl_rsp_if;
   logic                  valid;
   logic                  ready;
   shl_pkg::rsp_data_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/shear_linear_layer.sv
// Top level of the shear linear layer: input register, shear network, output register.
//
//   channel   dir   handshake          payload
//   req_chan  in    valid/ready        in_word_0..3 (128-bit block)
//   rsp_chan  out   valid/ready        out_word_0..3 (128-bit block)
//   csr_*     in    csr_we, no ready   csr_index, csr_wdata (matrix rows 0..7)
//
// One block per cycle sustained while rsp is taken; a block passes the input register,
// then the output register, which is loaded from the combinational four-stage network.
// Synchronous active-high reset clears both valid flags and loads the default matrix.
// A stalled rsp holds the output register; a full input register then holds too,
// and req ready drops only when both registers are full and rsp is not taken.
`timescale 1ns / 1ps
`default_nettype none

module shear_linear_layer (
   input  wire logic                             clock,
   input  wire logic                             reset,
   shl_req_if.sink                               req_chan,
   shl_rsp_if.source                             rsp_chan,
   input  wire logic                             csr_we,
   input  wire logic [shl_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [shl_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import shl_pkg::*;

   matrix_type   matrix_ff, matrix_in;
   matrix_type   rot_matrix;
   logic         s1_valid_ff, s1_valid_in;
   req_data_type s1_data_ff;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_data_type rsp_data_ff;
   logic         out_free;
   logic         s1_load;
   logic         rsp_load;

   byte_type     stg [NUM_STAGES+1][NUM_BYTES];

   // config
   always_comb begin
      matrix_in = matrix_ff;
      if (csr_we && (csr_index < CSR_INDEX_W'(NUM_ROWS))) begin
         matrix_in[csr_index[2:0]] = csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         matrix_ff <= MATRIX_RESET;
      end else begin
         matrix_ff <= matrix_in;
      end
   end

   assign rot_matrix = mat_rotate(matrix_ff);

   // handshake
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = !s1_valid_ff || out_free;
   assign s1_load        = req_chan.valid && req_chan.ready;
   assign rsp_load       = s1_valid_ff && out_free;
   assign s1_valid_in    = s1_load || (s1_valid_ff && !out_free);
   assign rsp_valid_in   = rsp_load || (rsp_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_data_ff <= req_chan.data;
      end
   end

   // unpack, byte 0 in the top bits of word 0
   for (genvar b = 0; b < 4; b++) begin : g_unpack
      assign stg[0][b]    = s1_data_ff.in_word_0[31-8*b -: 8];
      assign stg[0][4+b]  = s1_data_ff.in_word_1[31-8*b -: 8];
      assign stg[0][8+b]  = s1_data_ff.in_word_2[31-8*b -: 8];
      assign stg[0][12+b] = s1_data_ff.in_word_3[31-8*b -: 8];
   end

   // shear stages; pairs within a stage are disjoint
   for (genvar st = 0; st < NUM_STAGES; st++) begin : g_stage
      for (genvar i = 0; i < NUM_BYTES; i++) begin : g_cell
         if ((i & (1 << st)) == 0) begin : g_pair
            byte_type left_a, right_b;
            assign left_a  = stg[st][i] ^ mat_apply(matrix_ff, stg[st][i ^ (1 << st)]);
            assign right_b = stg[st][i ^ (1 << st)] ^ mat_apply(rot_matrix, left_a);
            assign stg[st+1][i]            = left_a ^ mat_apply(matrix_ff, right_b);
            assign stg[st+1][i ^ (1 << st)] = right_b;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff.out_word_0 <= {stg[NUM_STAGES][0],  stg[NUM_STAGES][1],
                                    stg[NUM_STAGES][2],  stg[NUM_STAGES][3]};
         rsp_data_ff.out_word_1 <= {stg[NUM_STAGES][4],  stg[NUM_STAGES][5],
                                    stg[NUM_STAGES][6],  stg[NUM_STAGES][7]};
         rsp_data_ff.out_word_2 <= {stg[NUM_STAGES][8],  stg[NUM_STAGES][9],
                                    stg[NUM_STAGES][10], stg[NUM_STAGES][11]};
         rsp_data_ff.out_word_3 <= {stg[NUM_STAGES][12], stg[NUM_STAGES][13],
                                    stg[NUM_STAGES][14], stg[NUM_STAGES][15]};
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.data  = rsp_data_ff;

   // checks
   a_req_lands: assert property (@(posedge clock) disable iff (reset)
      s1_load |=> s1_valid_ff)
      else $error("req transfer did not fill the input register");

   a_s1_holds: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !out_free) |=> (s1_valid_ff && $stable(s1_data_ff)))
      else $error("input register changed while output stalled");

   a_s1_moves: assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> rsp_valid_ff)
      else $error("block in input register was dropped");

   a_ready_full: assert property (@(posedge clock) disable iff (reset)
      !req_chan.ready |-> (s1_valid_ff && rsp_valid_ff && !rsp_chan.ready))
      else $error("req ready low without a full stalled pipeline");

endmodule

`default_nettype wire

FILE: bench/testbench.sv
// Self-checking bench for the shear linear layer: directed table, random blocks, matrix reloads.
`timescale 1ns / 1ps

module testbench;
   import shl_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int RANDOM_ITEMS = 1350;
   localparam int PHASES       = 5;
   localparam int SETTLE       = 4;
   localparam int MAX_REPORTS  = 20;

   localparam logic [3:0] IDX_SPARE_LO = 4'd8;
   localparam logic [3:0] IDX_SPARE_HI = 4'd15;

   localparam matrix_type ROWS_AT_RESET = {8'h82, 8'hDE, 8'hC0, 8'h01,
                                           8'h14, 8'hF5, 8'h73, 8'hC8};
   localparam matrix_type ROWS_ZERO     = '0;
   localparam matrix_type ROWS_ONES     = '1;
   localparam matrix_type ROWS_IDENTITY = {8'h01, 8'h02, 8'h04, 8'h08,
                                           8'h10, 8'h20, 8'h40, 8'h80};

   localparam logic [127:0] BLK_ZERO  = '0;
   localparam logic [127:0] BLK_ONES  = '1;
   localparam logic [127:0] BLK_COUNT = 128'h00112233_44556677_8899AABB_CCDDEEFF;
   localparam logic [127:0] BLK_AA    = {16{8'hAA}};
   localparam logic [127:0] BLK_55    = {16{8'h55}};
   localparam logic [127:0] BLK_TOP   = 128'h80 << 120;
   localparam logic [127:0] BLK_LOW   = 128'h01;

   typedef enum logic {ROW_WRITE, ROW_BLOCK} row_kind_type;

   typedef struct packed {
      row_kind_type kind;
      logic [3:0]   index;
      logic [7:0]   value;
      logic         has_want;
      logic [127:0] blk;
      logic [127:0] want;
   } stim_row_type;

   logic clock;
   logic reset;
   logic csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   shl_req_if req_chan ();
   shl_rsp_if rsp_chan ();

   shear_linear_layer u_top (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   matrix_type   rows_now;
   rsp_data_type sheared_q [$];
   stim_row_type stim_table [$];
   rsp_data_type want_now;
   bit           calm;
   int           err_count;
   int           cycles;
   int           blocks_sent;
   int           results_seen;
   int           matrix_loads;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // GF(2) product: XOR of the matrix columns picked by the set bits of x.
   function automatic logic [7:0] mix_byte(input matrix_type m, input logic [7:0] x);
      logic [7:0] acc;
      logic [7:0] col;
      acc = '0;
      for (int b = 0; b < 8; b++) begin
         for (int r = 0; r < 8; r++) col[7-r] = m[r][b];
         if (x[b]) acc ^= col;
      end
      return acc;
   endfunction

   function automatic matrix_type turn_clockwise(input matrix_type m);
      matrix_type q;
      for (int r = 0; r < 8; r++) begin
         for (int c = 0; c < 8; c++) q[r][7-c] = m[7-c][7-r];
      end
      return q;
   endfunction

   function automatic logic [127:0] shear_block(input logic [127:0] blk, input matrix_type m);
      logic [7:0]   lane [16];
      matrix_type   q;
      logic [127:0] res;
      int           j;
      q = turn_clockwise(m);
      for (int i = 0; i < 16; i++) lane[i] = blk[127-8*i -: 8];
      for (int st = 0; st < 4; st++) begin
         for (int i = 0; i < 16; i++) begin
            if ((i & (1 << st)) == 0) begin
               j = i | (1 << st);
               lane[i] ^= mix_byte(m, lane[j]);
               lane[j] ^= mix_byte(q, lane[i]);
               lane[i] ^= mix_byte(m, lane[j]);
            end
         end
      end
      for (int i = 0; i < 16; i++) res[127-8*i -: 8] = lane[i];
      return res;
   endfunction

   function automatic logic [127:0] random_block();
      logic [127:0] blk;
      case ($urandom_range(0, 9))
         0: blk = BLK_ZERO;
         1: blk = BLK_ONES;
         2: blk = 128'h1 << $urandom_range(0, 127);
         3: blk = {16{8'($urandom)}};
         4: blk = ~(128'h1 << $urandom_range(0, 127));
         default: blk = {$urandom, $urandom, $urandom, $urandom};
      endcase
      return blk;
   endfunction

   task automatic report_mismatch(input string msg);
      err_count++;
      if (err_count <= MAX_REPORTS) $display("MISMATCH cycle %0d: %s", cycles, msg);
   endtask

   task automatic check_word(input string name, input logic [31:0] got, input logic [31:0] want);
      if (got !== want) report_mismatch($sformatf("%s got %08h want %08h", name, got, want));
   endtask

   task automatic add_write(input logic [3:0] idx, input logic [7:0] val);
      stim_table.insert(stim_table.size(), '{ROW_WRITE, idx, val, 1'b0, BLK_ZERO, BLK_ZERO});
   endtask

   task automatic add_rows(input matrix_type m);
      for (int r = 0; r < NUM_ROWS; r++) add_write(4'(r), m[r]);
   endtask

   task automatic add_block(input logic [127:0] blk, input logic has_want,
                            input logic [127:0] want);
      stim_table.insert(stim_table.size(), '{ROW_BLOCK, 4'd0, 8'd0, has_want, blk, want});
   endtask

   task automatic build_table();
      add_block(BLK_ZERO, 1'b1, BLK_ZERO);
      add_block(BLK_ONES, 1'b0, BLK_ZERO);
      add_block(BLK_TOP, 1'b0, BLK_ZERO);
      add_block(BLK_LOW, 1'b0, BLK_ZERO);
      add_block(BLK_AA, 1'b0, BLK_ZERO);
      add_block(BLK_COUNT, 1'b0, BLK_ZERO);
      // zero matrix: network is a pass-through; writes above row 7 must not land
      add_rows(ROWS_ZERO);
      add_write(IDX_SPARE_LO, 8'hFF);
      add_write(IDX_SPARE_HI, 8'hFF);
      add_block(BLK_ONES, 1'b1, BLK_ONES);
      add_block(BLK_COUNT, 1'b1, BLK_COUNT);
      add_rows(ROWS_ONES);
      add_block(BLK_ONES, 1'b0, BLK_ZERO);
      add_block(BLK_TOP, 1'b0, BLK_ZERO);
      add_block(BLK_COUNT, 1'b0, BLK_ZERO);
      add_rows(ROWS_IDENTITY);
      add_block(BLK_COUNT, 1'b0, BLK_ZERO);
      add_block(BLK_55, 1'b0, BLK_ZERO);
      add_rows({8{8'h01}});
      add_block(BLK_LOW, 1'b0, BLK_ZERO);
      add_rows(ROWS_AT_RESET);
      add_block(BLK_COUNT, 1'b0, BLK_ZERO);
   endtask

   task automatic write_row(input logic [3:0] idx, input logic [7:0] val);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      @(posedge clock);
      if (idx < NUM_ROWS) rows_now[idx] = val;
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   task automatic load_matrix(input matrix_type m);
      for (int r = 0; r < NUM_ROWS; r++) write_row(4'(r), m[r]);
      write_row(4'($urandom_range(IDX_SPARE_LO, IDX_SPARE_HI)), 8'($urandom));
      matrix_loads++;
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_chan.valid = 1'b0;
      while (sheared_q.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic drive_block(input logic [127:0] blk, input logic has_want,
                              input logic [127:0] want);
      @(negedge clock);
      while (!calm && $urandom_range(0, 99) < 25) begin
         req_chan.valid = 1'b0;
         @(negedge clock);
      end
      req_chan.valid = 1'b1;
      req_chan.data  = req_data_type'(blk);
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      sheared_q.insert(sheared_q.size(),
                       rsp_data_type'(has_want ? want : shear_block(blk, rows_now)));
      blocks_sent++;
   endtask

   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_chan.ready = !reset && (calm || $urandom_range(0, 99) >= 25);
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d results outstanding", cycles, sheared_q.size());
         $display("Simulation FAILED");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
         results_seen++;
         if (sheared_q.size() == 0) begin
            report_mismatch($sformatf("transfer with nothing pending: %032h", rsp_chan.data));
         end else begin
            want_now = sheared_q.pop_front();
            check_word("out_word_0", rsp_chan.data.out_word_0, want_now.out_word_0);
            check_word("out_word_1", rsp_chan.data.out_word_1, want_now.out_word_1);
            check_word("out_word_2", rsp_chan.data.out_word_2, want_now.out_word_2);
            check_word("out_word_3", rsp_chan.data.out_word_3, want_now.out_word_3);
         end
      end
   end

   initial begin
      bit         last_block;
      matrix_type m;
      int         tail;
      reset          = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.data  = '0;
      csr_we         = 1'b0;
      csr_index      = '0;
      csr_wdata      = '0;
      calm           = 1'b0;
      err_count      = 0;
      blocks_sent    = 0;
      results_seen   = 0;
      matrix_loads   = 0;
      rows_now       = ROWS_AT_RESET;
      last_block     = 1'b0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      build_table();
      foreach (stim_table[k]) begin
         if (stim_table[k].kind == ROW_WRITE) begin
            if (last_block) wait_drained();
            write_row(stim_table[k].index, stim_table[k].value);
            last_block = 1'b0;
         end else begin
            drive_block(stim_table[k].blk, stim_table[k].has_want, stim_table[k].want);
            last_block = 1'b1;
         end
      end

      for (int p = 0; p < PHASES; p++) begin
         wait_drained();
         for (int r = 0; r < NUM_ROWS; r++) begin
            case (p)
               1:       m[r] = 8'hFF;
               2:       m[r] = 8'h01 << $urandom_range(0, 7);
               3:       m[r] = 8'h00;
               default: m[r] = 8'($urandom);
            endcase
         end
         load_matrix(m);
         calm = (p == 2);
         for (int n = 0; n < RANDOM_ITEMS / PHASES; n++) begin
            if (n == RANDOM_ITEMS / (2 * PHASES)) wait_drained();
            drive_block(random_block(), 1'b0, BLK_ZERO);
         end
         calm = 1'b0;
      end

      @(negedge clock);
      req_chan.valid = 1'b0;
      tail = 0;
      while (sheared_q.size() != 0 && tail < 2000) begin
         @(posedge clock);
         tail++;
      end
      repeat (SETTLE) @(posedge clock);
      if (sheared_q.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", sheared_q.size()));

      $display("Sent %0d blocks, checked %0d results across %0d matrix loads.",
               blocks_sent, results_seen, matrix_loads);
      $display("Matrices: reset, zero, all-ones, identity, one-hot rows, random; spare index writes.");
      if (err_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

FILE: shear_linear_layer.f
rtl/core/shl_pkg.sv
rtl/core/shl_if.sv
rtl/core/shear_linear_layer.sv
bench/testbench.sv
